/* src/tpt_pkg.sv */
`timescale 1ns / 1ps

package tpt_pkg;

  localparam int unsigned CapW = 5;
  localparam logic [CapW-1:0] CapReset = 5'd16;
  localparam logic [31:0] SlotKeyLimit = 32'h0000_ffff;

  localparam logic [1:0] CMD_GET = 2'd0;
  localparam logic [1:0] CMD_SET = 2'd1;
  localparam logic [1:0] CMD_DEL = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_MISS   = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_BADTAG = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] key;
    logic [31:0] data_in;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] data_out;
  } res_t;

  typedef struct packed {
    logic [31:0] tag;
    logic [31:0] value;
  } pair_t;

endpackage

/* src/tpt_cell.sv */
`timescale 1ns / 1ps

module tpt_cell (
  input  logic           clk_i,
  input  logic           en_i,
  input  tpt_pkg::pair_t d_i,
  output tpt_pkg::pair_t q_o
);

  tpt_pkg::pair_t pair_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pair_q <= d_i;
    end
  end

  assign q_o = pair_q;

endmodule

/* src/tpt_ctrl.sv */
`timescale 1ns / 1ps

module tpt_ctrl #(
  parameter int unsigned MaxSlots = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  tpt_pkg::item_t            item_i,
  output logic                      done_o,
  output tpt_pkg::res_t             res_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [tpt_pkg::CapW-1:0]  cfg_data_i,
  input  tpt_pkg::pair_t            tail_i,
  input  tpt_pkg::pair_t            pretail_i,
  output logic                      shift_en_o,
  output tpt_pkg::pair_t            feed_o
);

  localparam int unsigned SW   = $clog2(MaxSlots);
  localparam int unsigned CW   = $clog2(MaxSlots + 1);
  localparam int unsigned CmpW = (CW > tpt_pkg::CapW) ? CW : tpt_pkg::CapW;
  localparam logic [SW-1:0] LastStep = SW'(MaxSlots - 1);

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StRun  = 2'b10
  } state_e;

  state_e                    state_q, state_d;
  logic [SW-1:0]             step_q, step_d;
  logic [CW-1:0]             count_q, count_d;
  logic [tpt_pkg::CapW-1:0]  cap_q;
  logic                      hit_q, hit_d;
  logic [31:0]               acc_q, acc_d;
  logic                      done_q, done_d;
  tpt_pkg::item_t            item_q;
  tpt_pkg::res_t             res_q, res_d;

  logic            accept, last;
  logic [CW-1:0]   k_ext;
  logic            live, is_get, is_set, is_del, key_nz, by_tag, match, track, first, hit_now;
  logic            slot_match, full;
  logic [CmpW-1:0] cap_w, n_w, cap_eff, limit, cnt_w;

  assign accept      = start && !busy;
  assign busy        = (state_q == StRun);
  assign cfg_ready_o = 1'b1;
  assign shift_en_o  = busy;
  assign last        = (step_q == LastStep);

  always_comb begin
    k_ext      = CW'(step_q);
    live       = k_ext < count_q;
    is_get     = item_q.cmd == tpt_pkg::CMD_GET;
    is_set     = item_q.cmd == tpt_pkg::CMD_SET;
    is_del     = item_q.cmd == tpt_pkg::CMD_DEL;
    key_nz     = item_q.key != 32'd0;
    by_tag     = item_q.key > tpt_pkg::SlotKeyLimit;
    match      = live && (tail_i.tag == item_q.key);
    track      = ((is_set || is_del) && key_nz) || (is_get && by_tag);
    first      = track && match && !hit_q;
    hit_now    = hit_q || first;
    slot_match = (item_q.key - 32'd1) == 32'(step_q);

    cap_w   = CmpW'(cap_q);
    n_w     = CmpW'(MaxSlots);
    cap_eff = (cap_w > n_w) ? n_w : cap_w;
    limit   = (cap_eff == '0) ? '0 : cap_eff - CmpW'(1);
    cnt_w   = CmpW'(count_q);
    full    = (cnt_w >= limit) || (cnt_w >= n_w);

    feed_o = tail_i;
    if (is_set && key_nz) begin
      if (first) begin
        feed_o.value = item_q.data_in;
      end
      // tentative append into the first free slot
      if (k_ext == count_q) begin
        feed_o.tag   = item_q.key;
        feed_o.value = item_q.data_in;
      end
    end
    // close the gap: take the entry one slot further down the ring
    if (is_del && key_nz && hit_now) begin
      feed_o = pretail_i;
    end

    acc_d = acc_q;
    if (is_get && by_tag && first) begin
      acc_d = tail_i.value;
    end
    if (is_get && !by_tag && slot_match && live) begin
      acc_d = tail_i.tag;
    end

    res_d.status   = tpt_pkg::ST_MISS;
    res_d.data_out = 32'd0;
    count_d        = count_q;
    case (item_q.cmd)
      tpt_pkg::CMD_GET: begin
        if (by_tag) begin
          if (hit_now) begin
            res_d.status   = tpt_pkg::ST_OK;
            res_d.data_out = acc_d;
          end
        end else if (!key_nz) begin
          res_d.status   = tpt_pkg::ST_OK;
          res_d.data_out = 32'(cap_q);
        end else if (item_q.key <= 32'(cap_q)) begin
          res_d.status   = tpt_pkg::ST_OK;
          res_d.data_out = acc_d;
        end
      end
      tpt_pkg::CMD_SET: begin
        if (!key_nz) begin
          res_d.status = tpt_pkg::ST_BADTAG;
        end else if (hit_now) begin
          res_d.status = tpt_pkg::ST_OK;
        end else if (full) begin
          res_d.status = tpt_pkg::ST_FULL;
        end else begin
          res_d.status = tpt_pkg::ST_OK;
          count_d      = count_q + CW'(1);
        end
      end
      tpt_pkg::CMD_DEL: begin
        if (key_nz && hit_now) begin
          res_d.status = tpt_pkg::ST_OK;
          count_d      = count_q - CW'(1);
        end
      end
      default: begin
        res_d.status = tpt_pkg::ST_MISS;
      end
    endcase

    state_d = state_q;
    step_d  = step_q;
    hit_d   = hit_q;
    done_d  = 1'b0;
    case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = StRun;
          step_d  = '0;
          hit_d   = 1'b0;
        end
      end
      StRun: begin
        hit_d  = hit_now;
        step_d = step_q + SW'(1);
        if (last) begin
          state_d = StIdle;
          done_d  = 1'b1;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q  <= '0;
      count_q <= '0;
      cap_q   <= tpt_pkg::CapReset;
      hit_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      hit_q   <= hit_d;
      done_q  <= done_d;
      if (busy && last) begin
        count_q <= count_d;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
      acc_q  <= 32'd0;
    end else if (busy) begin
      acc_q <= acc_d;
    end
    if (busy && last) begin
      res_q <= res_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

/* src/tagged_pair_table_top.sv */
`timescale 1ns / 1ps

// channel   | signals                          | accepted when
// ----------+----------------------------------+-------------------------------
// command   | start, busy, item_i              | start && !busy
// result    | done_o, res_o                    | done_o (one cycle, no stall)
// config    | cfg_valid_i, cfg_ready_o, cfg_data_i | cfg_valid_i && cfg_ready_o
//
// Each item rotates the cell ring once: when the rotation ends the result is shown
// for one cycle with done_o; busy drops in that same cycle, so a new item can be taken
// then, and not while the previous item is still being processed.
// Reset clears the entry count and sets capacity to 16; cell contents are not cleared.
// Config is always ready. The result side has no backpressure.

module tagged_pair_table_top #(
  parameter int unsigned MAX_SLOTS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  tpt_pkg::item_t            item_i,
  output logic                      done_o,
  output tpt_pkg::res_t             res_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [tpt_pkg::CapW-1:0]  cfg_data_i
);

  tpt_pkg::pair_t cell_q [MAX_SLOTS];
  tpt_pkg::pair_t feed;
  logic           shift_en;

  tpt_ctrl #(
    .MaxSlots (MAX_SLOTS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .item_i      (item_i),
    .done_o      (done_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .tail_i      (cell_q[MAX_SLOTS-1]),
    .pretail_i   (cell_q[MAX_SLOTS-2]),
    .shift_en_o  (shift_en),
    .feed_o      (feed)
  );

  for (genvar i = 0; i < MAX_SLOTS; i++) begin : g_cell
    if (i == 0) begin : g_head
      tpt_cell u_cell (
        .clk_i (clk_i),
        .en_i  (shift_en),
        .d_i   (feed),
        .q_o   (cell_q[i])
      );
    end else begin : g_body
      tpt_cell u_cell (
        .clk_i (clk_i),
        .en_i  (shift_en),
        .d_i   (cell_q[i-1]),
        .q_o   (cell_q[i])
      );
    end
  end

endmodule

/* src/tpt_checker.sv */
`timescale 1ns / 1ps

module tpt_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input logic          done_o,
  input tpt_pkg::res_t res_o
);

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while busy");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted item did not start");

  a_single_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_fall_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("item finished without a result");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.status != tpt_pkg::ST_OK) |-> (res_o.data_out == 32'd0))
    else $error("nonzero data on failed item");

endmodule

bind tagged_pair_table_top tpt_checker u_tpt_checker (.*);

/* test/tb_tagged_pair_table_top.sv */
`timescale 1ns / 1ps

module tb_tagged_pair_table_top;

  localparam int unsigned JarSlots = 16;
  localparam logic [1:0] CmdUndef = 2'd3;
  localparam int unsigned SettleCycles = JarSlots + 4;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  tpt_pkg::item_t item_i = '0;
  logic done_o;
  tpt_pkg::res_t res_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [tpt_pkg::CapW-1:0] cfg_data_i = '0;

  tagged_pair_table_top #(
    .MAX_SLOTS(JarSlots)
  ) uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .item_i(item_i),
    .done_o(done_o),
    .res_o(res_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i(cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predicted table contents
  logic [31:0] jar_tag [JarSlots];
  logic [31:0] jar_val [JarSlots];
  int jar_count = 0;
  logic [tpt_pkg::CapW-1:0] jar_cap = tpt_pkg::CapReset;

  tpt_pkg::item_t cmd_q[$];
  tpt_pkg::res_t reply_q[$];
  logic cmd_fired = 1'b0;
  int gap_pct = 0;
  int errors = 0;
  logic [31:0] tag_pool [24];

  task automatic log_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic tpt_pkg::res_t jar_apply(tpt_pkg::item_t it);
    tpt_pkg::res_t r;
    int idx;
    int eff;
    int lim;
    r.status = tpt_pkg::ST_MISS;
    r.data_out = '0;
    idx = jar_count;
    for (int i = jar_count - 1; i >= 0; i--) begin
      if (jar_tag[i] == it.key) idx = i;
    end
    case (it.cmd)
      tpt_pkg::CMD_GET: begin
        if (it.key > tpt_pkg::SlotKeyLimit) begin
          if (idx < jar_count) begin
            r.status = tpt_pkg::ST_OK;
            r.data_out = jar_val[idx];
          end
        end else if (it.key == 0) begin
          r.status = tpt_pkg::ST_OK;
          r.data_out = 32'(jar_cap);
        end else if (it.key <= 32'(jar_cap)) begin
          if (it.key - 1 < 32'(jar_count)) r.data_out = jar_tag[it.key - 1];
          r.status = tpt_pkg::ST_OK;
        end
      end
      tpt_pkg::CMD_SET: begin
        if (it.key == 0) begin
          r.status = tpt_pkg::ST_BADTAG;
        end else if (idx < jar_count) begin
          jar_val[idx] = it.data_in;
          r.status = tpt_pkg::ST_OK;
        end else begin
          eff = (jar_cap > JarSlots) ? JarSlots : int'(jar_cap);
          lim = (eff > 0) ? eff - 1 : 0;
          if (jar_count >= lim || jar_count >= JarSlots) begin
            r.status = tpt_pkg::ST_FULL;
          end else begin
            jar_tag[jar_count] = it.key;
            jar_val[jar_count] = it.data_in;
            jar_count++;
            r.status = tpt_pkg::ST_OK;
          end
        end
      end
      tpt_pkg::CMD_DEL: begin
        if (it.key != 0 && idx < jar_count) begin
          for (int i = idx; i + 1 < jar_count; i++) begin
            jar_tag[i] = jar_tag[i + 1];
            jar_val[i] = jar_val[i + 1];
          end
          jar_count--;
          r.status = tpt_pkg::ST_OK;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // driver: holds an item until it is taken
  always @(negedge clk_i) begin
    if (!start || cmd_fired) begin
      if (cmd_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
        item_i <= cmd_q.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    tpt_pkg::res_t want;
    cmd_fired <= start && !busy;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) jar_cap = cfg_data_i;
      if (done_o) begin
        if (reply_q.size() == 0) begin
          log_mismatch($sformatf("result with nothing pending: status %0d data %h",
                                 res_o.status, res_o.data_out));
        end else begin
          want = reply_q.pop_front();
          if (res_o.status !== want.status)
            log_mismatch($sformatf("status got %0d want %0d", res_o.status, want.status));
          if (res_o.data_out !== want.data_out)
            log_mismatch($sformatf("data_out got %h want %h", res_o.data_out,
                                   want.data_out));
        end
      end
      if (start && !busy) reply_q.push_back(jar_apply(item_i));
    end
  end

  task automatic push_cmd(logic [1:0] c, logic [31:0] k, logic [31:0] d);
    tpt_pkg::item_t it;
    it.cmd = c;
    it.key = k;
    it.data_in = d;
    cmd_q.push_back(it);
  endtask

  task automatic drain();
    do @(posedge clk_i); while (cmd_q.size() != 0 || start || reply_q.size() != 0);
  endtask

  task automatic write_cap(logic [tpt_pkg::CapW-1:0] v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic tpt_pkg::item_t rand_item();
    tpt_pkg::item_t it;
    int c;
    int k;
    c = $urandom_range(99);
    k = $urandom_range(99);
    if (c < 40) it.cmd = tpt_pkg::CMD_SET;
    else if (c < 70) it.cmd = tpt_pkg::CMD_GET;
    else if (c < 92) it.cmd = tpt_pkg::CMD_DEL;
    else it.cmd = CmdUndef;
    if (k < 70) it.key = tag_pool[$urandom_range(23)];
    else if (k < 82) it.key = $urandom_range(20, 1);
    else if (k < 86) it.key = '0;
    else if (k < 90) it.key = $urandom_range(32'h0000_ffff, 1);
    else it.key = $urandom;
    it.data_in = $urandom;
    return it;
  endfunction

  task automatic run_batch(logic [tpt_pkg::CapW-1:0] cap, int n);
    write_cap(cap);
    repeat (n) cmd_q.push_back(rand_item());
    drain();
  endtask

  initial begin
    for (int i = 0; i < 22; i++) tag_pool[i] = {16'($urandom_range(16'hffff, 1)), 16'($urandom)};
    tag_pool[22] = $urandom_range(32'h0000_ffff, 1);
    tag_pool[23] = 32'hffff_ffff;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    gap_pct = 18;
    write_cap(5'd16);
    push_cmd(tpt_pkg::CMD_GET, 32'h0, 32'h0);
    push_cmd(tpt_pkg::CMD_SET, 32'h0, 32'h1234_5678);
    push_cmd(tpt_pkg::CMD_SET, 32'hffff_ffff, 32'h0);
    push_cmd(tpt_pkg::CMD_SET, 32'h1, 32'hffff_ffff);
    push_cmd(tpt_pkg::CMD_SET, 32'h0001_0000, 32'h5a5a_5a5a);
    push_cmd(tpt_pkg::CMD_GET, 32'h0001_0000, 32'h0);
    push_cmd(tpt_pkg::CMD_GET, 32'hffff_ffff, 32'hffff_ffff);
    push_cmd(tpt_pkg::CMD_GET, 32'h1, 32'h0);
    push_cmd(tpt_pkg::CMD_GET, 32'h3, 32'h0);
    push_cmd(tpt_pkg::CMD_GET, 32'h4, 32'h0);
    push_cmd(tpt_pkg::CMD_GET, 32'd16, 32'h0);
    push_cmd(tpt_pkg::CMD_GET, 32'd17, 32'h0);
    push_cmd(tpt_pkg::CMD_GET, 32'h0000_ffff, 32'h0);
    push_cmd(tpt_pkg::CMD_GET, 32'h1234_5678, 32'h0);
    push_cmd(tpt_pkg::CMD_SET, 32'hffff_ffff, 32'ha5a5_a5a5);
    push_cmd(tpt_pkg::CMD_DEL, 32'h1, 32'h0);
    push_cmd(tpt_pkg::CMD_GET, 32'h2, 32'h0);
    push_cmd(tpt_pkg::CMD_GET, 32'hffff_ffff, 32'h0);
    push_cmd(tpt_pkg::CMD_DEL, 32'h0, 32'h0);
    push_cmd(tpt_pkg::CMD_DEL, 32'h1234_5678, 32'h0);
    push_cmd(CmdUndef, 32'hffff_ffff, 32'hffff_ffff);
    push_cmd(tpt_pkg::CMD_DEL, 32'hffff_ffff, 32'h0);
    push_cmd(tpt_pkg::CMD_GET, 32'h1, 32'h0);
    drain();

    run_batch(5'd2, 90);
    run_batch(5'd31, 90);
    gap_pct = 53;
    run_batch(5'd1, 80);
    run_batch(5'd0, 80);
    run_batch(5'd16, 90);
    gap_pct = 0;
    run_batch(5'($urandom_range(16, 2)), 100);
    run_batch(5'd9, 90);

    repeat (SettleCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_tagged_pair_table_top: PASS");
    end else begin
      $display("tb_tagged_pair_table_top: FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_tagged_pair_table_top: FAIL");
    $finish;
  end

endmodule

/* files.f */
src/tpt_pkg.sv
src/tpt_cell.sv
src/tpt_ctrl.sv
src/tagged_pair_table_top.sv
src/tpt_checker.sv
test/tb_tagged_pair_table_top.sv
